// File: design/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants and codes for the gradient colour map block.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int POS_W    = 16;
    localparam int SMP_W    = 16;
    localparam int CHAN_W   = 8;
    localparam int COLOUR_W = 3 * CHAN_W;
    localparam int ENTRY_W  = POS_W + COLOUR_W;
    localparam int CNT_W    = 5;
    localparam int IDXIN_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_NUM_W = 2 * POS_W;

    localparam int DEF_MAX_STOPS = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    localparam logic [1:0] ST_MAPPED     = 2'd0;
    localparam logic [1:0] ST_RANGE      = 2'd1;
    localparam logic [1:0] ST_NO_BRACKET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 2'd3;

endpackage

// File: design/gcm_ram.sv
// ----------------------------------------------------------------------------
// gcm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/gcm_div.sv
// ----------------------------------------------------------------------------
// gcm_div
// Restoring divider, one quotient bit per cycle. The numerator's upper half
// must be below the denominator, so the quotient fits in the lower half.
// ----------------------------------------------------------------------------
module gcm_div
    import gcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [POS_W-1:0]     i_den,
    output logic                 o_done,
    output logic [POS_W-1:0]     o_quot
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [$clog2(POS_W+1)-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0]           r_rem, n_rem;
    logic [POS_W-1:0]           r_q, n_q;
    logic [POS_W-1:0]           r_den, n_den;
    logic [POS_W:0]             w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_q     = r_q;
        n_den   = r_den;
        w_trial = {r_rem, r_q[POS_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num[DIV_NUM_W-1:POS_W];
            n_q    = i_num[POS_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = POS_W'(w_trial - {1'b0, r_den});
                n_q   = {r_q[POS_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[POS_W-1:0];
                n_q   = {r_q[POS_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ($clog2(POS_W+1))'(POS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: design/gradient_colour_map.sv
// ----------------------------------------------------------------------------
// gradient_colour_map
// Piecewise linear colour map: normalizes a sample, finds the bracketing
// colour stops in the stop RAM and blends their colours.
//
//   channel  signals                                     flow control
//   input    start, busy, i_opcode, i_sample, i_stop_*   start & !busy
//   result   o_valid, o_red, o_green, o_blue, o_map_status  strobe, no stall
//   config   i_cfg_valid, o_cfg_ready, i_cfg_index/data   valid & ready
//
// A load never raises busy. A map out of range returns its result in the cycle
// after its transfer and never raises busy. Otherwise busy stays high through
// the position division (skipped for a degenerate range), a read and a compare
// state per stop scanned in the RAM, a further read state when the scan runs
// past the last stop, and a multiply state and a blend division per colour
// channel when the position falls between stops. The result strobe comes in the first cycle with busy low again.
// The shared radix-2 divider and the one-read-per-stop RAM scan set the rate.
// Reset is synchronous; the stop RAM has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module gradient_colour_map
    import gcm_pkg::*;
#(
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_opcode,
    input  logic [SMP_W-1:0]      i_sample,
    input  logic [IDXIN_W-1:0]    i_stop_index,
    input  logic [POS_W-1:0]      i_stop_position,
    input  logic [CHAN_W-1:0]     i_stop_red,
    input  logic [CHAN_W-1:0]     i_stop_green,
    input  logic [CHAN_W-1:0]     i_stop_blue,
    output logic                  o_valid,
    output logic [CHAN_W-1:0]     o_red,
    output logic [CHAN_W-1:0]     o_green,
    output logic [CHAN_W-1:0]     o_blue,
    output logic [1:0]            o_map_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COLOUR_W-1:0]   i_cfg_data
);

    localparam int AW   = $clog2(MAX_STOPS);
    localparam int CW   = $clog2(MAX_STOPS + 1);
    localparam int NW   = (CW > CNT_W) ? CW : CNT_W;
    localparam int IW   = (NW > IDXIN_W) ? NW : IDXIN_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIVP = 6'b000010,
        S_RD   = 6'b000100,
        S_CMP  = 6'b001000,
        S_MUL  = 6'b010000,
        S_DIVC = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [SMP_W-1:0]    r_min, r_max;
    logic [COLOUR_W-1:0] r_blank;
    logic [NW-1:0]       r_count;
    logic [POS_W-1:0]    r_p, n_p;
    logic [NW-1:0]       r_idx, n_idx;
    logic [ENTRY_W-1:0]  r_lo, n_lo;
    logic [ENTRY_W-1:0]  r_hi, n_hi;
    logic [1:0]          r_ch, n_ch;
    logic [COLOUR_W-1:0] r_mix, n_mix;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [POS_W-1:0]    r_den, n_den;
    logic                r_dstart, n_dstart;

    logic                r_valid, n_valid;
    logic [COLOUR_W-1:0] r_colour, n_colour;
    logic [1:0]          r_status, n_status;

    logic                w_accept;
    logic                w_we;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [POS_W-1:0]    w_pos;
    logic [SMP_W-1:0]    w_diff, w_span;
    logic [POS_W-1:0]    w_d, w_e, w_de;
    logic [CHAN_W-1:0]   w_clo, w_chi;
    logic [COLOUR_W-1:0] w_bsum;
    logic                w_ddone;
    logic [POS_W-1:0]    w_quot;
    logic [NW-1:0]       w_cnt_in;

    assign w_accept = start && !busy;
    assign w_we     = w_accept && (i_opcode == OP_LOAD)
                      && (IW'(i_stop_index) < IW'(MAX_STOPS));

    gcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_stop_index)),
        .i_wdata ({i_stop_position, i_stop_red, i_stop_green, i_stop_blue}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    gcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    assign w_pos  = w_rdata[ENTRY_W-1:COLOUR_W];
    assign w_diff = i_sample - r_min;
    assign w_span = r_max - r_min;
    assign w_d    = r_hi[ENTRY_W-1:COLOUR_W] - r_lo[ENTRY_W-1:COLOUR_W];
    assign w_e    = r_p - r_lo[ENTRY_W-1:COLOUR_W];
    assign w_de   = r_hi[ENTRY_W-1:COLOUR_W] - r_p;

    always_comb begin
        case (r_ch)
            2'd0: begin
                w_clo = r_lo[23:16];
                w_chi = r_hi[23:16];
            end
            2'd1: begin
                w_clo = r_lo[15:8];
                w_chi = r_hi[15:8];
            end
            default: begin
                w_clo = r_lo[7:0];
                w_chi = r_hi[7:0];
            end
        endcase
    end

    // The blend never exceeds 255 * d, so it fits in 24 bits.
    assign w_bsum = COLOUR_W'(w_clo) * COLOUR_W'(w_de) + COLOUR_W'(w_chi) * COLOUR_W'(w_e);

    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_idx    = r_idx;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_ch     = r_ch;
        n_mix    = r_mix;
        n_num    = r_num;
        n_den    = r_den;
        n_dstart = 1'b0;
        n_valid  = 1'b0;
        n_colour = r_colour;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == OP_MAP)) begin
                    n_idx = '0;
                    if (i_sample < r_min || i_sample > r_max) begin
                        n_valid  = 1'b1;
                        n_colour = r_blank;
                        n_status = ST_RANGE;
                    end else if (r_max == r_min) begin
                        n_p     = '0;
                        n_state = S_RD;
                    end else begin
                        // diff * 65535 without a multiplier.
                        n_num    = {w_diff, {POS_W{1'b0}}} - DIV_NUM_W'(w_diff);
                        n_den    = w_span;
                        n_dstart = 1'b1;
                        n_state  = S_DIVP;
                    end
                end
            end
            S_DIVP: begin
                if (w_ddone) begin
                    n_p     = w_quot;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_idx >= r_count) begin
                    n_valid  = 1'b1;
                    n_colour = r_blank;
                    n_status = ST_NO_BRACKET;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_pos == r_p) begin
                    n_valid  = 1'b1;
                    n_colour = w_rdata[COLOUR_W-1:0];
                    n_status = ST_MAPPED;
                    n_state  = S_IDLE;
                end else if (w_pos > r_p) begin
                    if (r_idx == '0) begin
                        n_valid  = 1'b1;
                        n_colour = r_blank;
                        n_status = ST_NO_BRACKET;
                        n_state  = S_IDLE;
                    end else begin
                        n_hi    = w_rdata;
                        n_ch    = 2'd0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_lo    = w_rdata;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_MUL: begin
                n_num    = DIV_NUM_W'(w_bsum);
                n_den    = w_d;
                n_dstart = 1'b1;
                n_state  = S_DIVC;
            end
            S_DIVC: begin
                if (w_ddone) begin
                    n_mix = {r_mix[COLOUR_W-CHAN_W-1:0], w_quot[CHAN_W-1:0]};
                    if (r_ch == 2'd2) begin
                        n_valid  = 1'b1;
                        n_colour = {r_mix[COLOUR_W-CHAN_W-1:0], w_quot[CHAN_W-1:0]};
                        n_status = ST_MAPPED;
                        n_state  = S_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_cnt_in = (NW'(i_cfg_data[CNT_W-1:0]) > NW'(MAX_STOPS))
                      ? NW'(MAX_STOPS) : NW'(i_cfg_data[CNT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_dstart <= 1'b0;
            r_min    <= '0;
            r_max    <= '1;
            r_blank  <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_dstart <= n_dstart;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RANGE_MIN:  r_min   <= i_cfg_data[SMP_W-1:0];
                    REG_RANGE_MAX:  r_max   <= i_cfg_data[SMP_W-1:0];
                    REG_BLANK:      r_blank <= i_cfg_data;
                    REG_STOP_COUNT: r_count <= w_cnt_in;
                    default: ;
                endcase
            end
        end
        r_p      <= n_p;
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ch     <= n_ch;
        r_mix    <= n_mix;
        r_num    <= n_num;
        r_den    <= n_den;
        r_colour <= n_colour;
        r_status <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_valid;
    assign o_red        = r_colour[23:16];
    assign o_green      = r_colour[15:8];
    assign o_blue       = r_colour[7:0];
    assign o_map_status = r_status;

`ifndef ASSERT_OFF
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_map_status == ST_MAPPED || o_map_status == ST_RANGE
                     || o_map_status == ST_NO_BRACKET))
        else $error("invalid map status");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode == OP_LOAD) |=> (!o_valid && !busy))
        else $error("load transfer produced a result or busy");

    a_range_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_map_status == ST_RANGE) |-> $past(w_accept))
        else $error("range status without a map transfer");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |-> (r_state == S_DIVP || r_state == S_DIVC))
        else $error("divider started outside a divide state");
`endif

endmodule

// File: verif/gradient_colour_map_tb.sv
// ----------------------------------------------------------------------------
// gradient_colour_map_tb
// Self-checking testbench for the gradient colour map. A directed table loads
// a full stop table and probes the range, degenerate range, inverted range,
// saturated stop count and missing bracket cases. Random phases then reload
// well-formed ascending stop tables, reprogram the range registers and map
// random samples, with a few stray stop loads mixed in. Each result is checked
// in arrival order against its directed expectation or a behavioral predictor.
// ----------------------------------------------------------------------------
module gradient_colour_map_tb;
    import gcm_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [1:0]        status;
    } t_colour_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  opcode;
        logic [SMP_W-1:0]      sample;
        logic [IDXIN_W-1:0]    slot;
        logic [POS_W-1:0]      pos;
        logic [COLOUR_W-1:0]   rgb;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [COLOUR_W-1:0]   reg_data;
        bit                    typed;
        t_colour_res           want;
    } t_stim_row;

    localparam int SETTLE_CYCLES = 120;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [SMP_W-1:0]     i_sample;
    logic [IDXIN_W-1:0]   i_stop_index;
    logic [POS_W-1:0]     i_stop_position;
    logic [CHAN_W-1:0]    i_stop_red;
    logic [CHAN_W-1:0]    i_stop_green;
    logic [CHAN_W-1:0]    i_stop_blue;
    logic                 o_valid;
    logic [CHAN_W-1:0]    o_red;
    logic [CHAN_W-1:0]    o_green;
    logic [CHAN_W-1:0]    o_blue;
    logic [1:0]           o_map_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COLOUR_W-1:0]  i_cfg_data;

    gradient_colour_map dut (.*);

    // Predictor copy of the block state.
    logic [SMP_W-1:0]    lo_bound;
    logic [SMP_W-1:0]    hi_bound;
    logic [COLOUR_W-1:0] blank_rgb;
    int                  stops_used;
    logic [POS_W-1:0]    stop_pos [DEF_MAX_STOPS];
    logic [COLOUR_W-1:0] stop_rgb [DEF_MAX_STOPS];

    t_colour_res pending_colours [$];
    t_stim_row   directed [$];
    int          errors;
    int          items_sent;
    int          loads_sent;
    int          status_seen [4];
    int          gap_max;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] c_lo,
            logic [CHAN_W-1:0] c_hi, longint unsigned d, longint unsigned e);
        longint unsigned acc;
        acc = (longint'(c_lo) * (d - e) + longint'(c_hi) * e) / d;
        return acc[CHAN_W-1:0];
    endfunction

    function automatic t_colour_res predict_colour(logic [SMP_W-1:0] smp);
        longint unsigned p, d, e;
        t_colour_res     res;
        logic [COLOUR_W-1:0] c_lo, c_hi;
        res = '{blank_rgb[23:16], blank_rgb[15:8], blank_rgb[7:0], ST_RANGE};
        if (smp < lo_bound || smp > hi_bound) return res;
        if (hi_bound == lo_bound)
            p = 0;
        else
            p = (longint'(smp - lo_bound) * 65535) / longint'(hi_bound - lo_bound);
        res.status = ST_NO_BRACKET;
        for (int i = 0; i < stops_used; i++) begin
            if (stop_pos[i] == p) begin
                return '{stop_rgb[i][23:16], stop_rgb[i][15:8], stop_rgb[i][7:0],
                         ST_MAPPED};
            end
            if (stop_pos[i] > p) begin
                // A position below the first stop has nothing to blend from.
                if (i == 0) return res;
                d = stop_pos[i] - stop_pos[i-1];
                e = p - stop_pos[i-1];
                c_lo = stop_rgb[i-1];
                c_hi = stop_rgb[i];
                return '{blend_chan(c_lo[23:16], c_hi[23:16], d, e),
                         blend_chan(c_lo[15:8], c_hi[15:8], d, e),
                         blend_chan(c_lo[7:0], c_hi[7:0], d, e), ST_MAPPED};
            end
        end
        return res;
    endfunction

    // Result checker: the block cannot stall results, so check every strobe.
    always @(posedge i_clk) begin
        t_colour_res want;
        if (i_rst_n && o_valid) begin
            if (pending_colours.size() == 0) begin
                $display("%0t: result with nothing expected: %h %h %h status %0d",
                         $time, o_red, o_green, o_blue, o_map_status);
                errors++;
            end else begin
                want = pending_colours.pop_front();
                status_seen[o_map_status]++;
                if (o_red !== want.red) begin
                    $display("%0t: red expected %h actual %h", $time, want.red, o_red);
                    errors++;
                end
                if (o_green !== want.green) begin
                    $display("%0t: green expected %h actual %h", $time, want.green,
                             o_green);
                    errors++;
                end
                if (o_blue !== want.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue, o_blue);
                    errors++;
                end
                if (o_map_status !== want.status) begin
                    $display("%0t: map_status expected %0d actual %0d", $time,
                             want.status, o_map_status);
                    errors++;
                end
            end
        end
    end

    // Called in a clock-edge step; leaves start high when no gap follows.
    task automatic issue_item(logic op, logic [SMP_W-1:0] smp, logic [IDXIN_W-1:0] slot,
            logic [POS_W-1:0] pos, logic [COLOUR_W-1:0] rgb, bit typed,
            t_colour_res want);
        int gap;
        start           <= 1'b1;
        i_opcode        <= op;
        i_sample        <= smp;
        i_stop_index    <= slot;
        i_stop_position <= pos;
        {i_stop_red, i_stop_green, i_stop_blue} <= rgb;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (op == OP_LOAD) begin
            stop_pos[slot] = pos;
            stop_rgb[slot] = rgb;
            loads_sent++;
        end else begin
            pending_colours = {pending_colours, (typed ? want : predict_colour(smp))};
        end
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Registers change only once the block has drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOUR_W-1:0] data);
        start <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_RANGE_MIN:  lo_bound  = data[SMP_W-1:0];
            REG_RANGE_MAX:  hi_bound  = data[SMP_W-1:0];
            REG_BLANK:      blank_rgb = data;
            REG_STOP_COUNT: stops_used = (data[CNT_W-1:0] > DEF_MAX_STOPS) ?
                                         DEF_MAX_STOPS : int'(data[CNT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic add_row(t_stim_row r);
        directed = {directed, r};
    endtask

    function automatic t_stim_row row_load(int slot, int pos, logic [COLOUR_W-1:0] rgb);
        t_stim_row r;
        r = '{kind: ROW_ITEM, default: '0};
        r.opcode = OP_LOAD;
        r.slot = IDXIN_W'(slot); r.pos = POS_W'(pos); r.rgb = rgb;
        return r;
    endfunction

    function automatic t_stim_row row_map(int smp, bit typed, t_colour_res want);
        t_stim_row r;
        r = '{kind: ROW_ITEM, default: '0};
        r.opcode = OP_MAP; r.sample = SMP_W'(smp);
        r.typed = typed; r.want = want;
        return r;
    endfunction

    function automatic t_stim_row row_cfg(logic [CFG_IDX_W-1:0] idx,
            logic [COLOUR_W-1:0] data);
        t_stim_row r;
        r = '{kind: ROW_CFG, default: '0};
        r.reg_idx = idx; r.reg_data = data;
        return r;
    endfunction

    initial begin
        t_stim_row   row;
        t_colour_res none;
        int          n_stops;
        int          batch;
        int          pick;
        int          pos_list [$];
        logic [SMP_W-1:0] smp, a, b;

        none = '{default: '0};
        errors = 0; items_sent = 0; loads_sent = 0; gap_max = 13;
        status_seen = '{default: 0};
        lo_bound = '0; hi_bound = '1; blank_rgb = '0; stops_used = 0;
        for (int i = 0; i < DEF_MAX_STOPS; i++) begin
            stop_pos[i] = '0;
            stop_rgb[i] = '0;
        end
        i_rst_n <= 1'b0; start <= 1'b0; i_opcode <= OP_LOAD; i_sample <= '0;
        i_stop_index <= '0; i_stop_position <= '0; i_stop_red <= '0;
        i_stop_green <= '0; i_stop_blue <= '0; i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_RANGE_MIN; i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. With no stops in use every sample misses a bracket.
        add_row(row_map(16'h0000, 1, '{8'h00, 8'h00, 8'h00, ST_NO_BRACKET}));
        add_row(row_map(16'hffff, 1, '{8'h00, 8'h00, 8'h00, ST_NO_BRACKET}));
        for (int i = 0; i < DEF_MAX_STOPS; i++)
            add_row(row_load(i, (i == 15) ? 65535 : i * 4096,
                             {8'(i * 17), 8'(255 - i * 17), 8'(i * 40)}));
        add_row(row_cfg(REG_BLANK, 24'h123456));
        add_row(row_cfg(REG_STOP_COUNT, 24'hffff1f));  // saturates
        add_row(row_cfg(REG_RANGE_MIN, 24'h000100));
        add_row(row_cfg(REG_RANGE_MAX, 24'h00ff00));
        add_row(row_map(16'h00ff, 1, '{8'h12, 8'h34, 8'h56, ST_RANGE}));
        add_row(row_map(16'hff01, 1, '{8'h12, 8'h34, 8'h56, ST_RANGE}));
        add_row(row_map(16'h0100, 1, '{8'h00, 8'hff, 8'h00, ST_MAPPED}));
        add_row(row_map(16'hff00, 1, '{8'hff, 8'h00, 8'h58, ST_MAPPED}));
        add_row(row_map(16'h8000, 0, none));
        add_row(row_cfg(REG_RANGE_MIN, 24'h004000));
        add_row(row_cfg(REG_RANGE_MAX, 24'h004000));
        add_row(row_map(16'h4000, 1, '{8'h00, 8'hff, 8'h00, ST_MAPPED}));
        add_row(row_cfg(REG_RANGE_MIN, 24'h009000));
        add_row(row_cfg(REG_RANGE_MAX, 24'h001000));
        add_row(row_map(16'h5000, 1, '{8'h12, 8'h34, 8'h56, ST_RANGE}));
        add_row(row_cfg(REG_RANGE_MIN, 24'h000000));
        add_row(row_cfg(REG_RANGE_MAX, 24'hffffff));
        add_row(row_cfg(REG_STOP_COUNT, 24'h000002));
        add_row(row_map(16'hffff, 1, '{8'h12, 8'h34, 8'h56, ST_NO_BRACKET}));
        add_row(row_map(16'h0800, 0, none));

        foreach (directed[k]) begin
            row = directed[k];
            if (row.kind == ROW_CFG)
                write_reg(row.reg_idx, row.reg_data);
            else
                issue_item(row.opcode, row.sample, row.slot, row.pos, row.rgb,
                           row.typed, row.want);
        end

        // Random phases. Every slot is written above, so any stop count is legal.
        while (items_sent < 1150) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            case ($urandom_range(0, 5))
                0: begin a = '0; b = '1; end
                1: begin a = $urandom; b = a; end
                2: begin a = $urandom; b = $urandom; end    // may be inverted
                3: begin a = '1; b = '1; end
                default: begin
                    a = $urandom; b = $urandom;
                    if (a > b) begin smp = a; a = b; b = smp; end
                end
            endcase
            write_reg(REG_RANGE_MIN, {8'($urandom), a});
            write_reg(REG_RANGE_MAX, {8'($urandom), b});
            write_reg(REG_BLANK, 24'($urandom));

            if ($urandom_range(0, 1) == 0) begin
                n_stops = $urandom_range(0, DEF_MAX_STOPS);
                pos_list.delete();
                for (int i = 0; i < n_stops; i++)
                    pos_list = {pos_list, int'($urandom_range(0, 65535))};
                if (n_stops > 1 && $urandom_range(0, 1) == 0) begin
                    pos_list[0] = 0;
                    pos_list[1] = 65535;
                end
                pos_list.sort();
                for (int i = 0; i < n_stops; i++)
                    issue_item(OP_LOAD, 16'($urandom), IDXIN_W'(i), POS_W'(pos_list[i]),
                               24'($urandom), 0, none);
                if (n_stops == DEF_MAX_STOPS && $urandom_range(0, 1) == 0)
                    write_reg(REG_STOP_COUNT, {19'($urandom), 5'($urandom_range(16, 31))});
                else
                    write_reg(REG_STOP_COUNT, {19'($urandom), 5'(n_stops)});
            end

            batch = $urandom_range(30, 60);
            repeat (batch) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    // Stray load: may break the ascending order, still defined.
                    issue_item(OP_LOAD, 16'($urandom), 4'($urandom), 16'($urandom),
                               24'($urandom), 0, none);
                end else begin
                    if (pick < 60 && lo_bound <= hi_bound)
                        smp = $urandom_range(lo_bound, hi_bound);
                    else if (pick < 72)
                        smp = stop_pos[$urandom_range(0, DEF_MAX_STOPS - 1)] + lo_bound;
                    else if (pick < 80)
                        case ($urandom_range(0, 3))
                            0: smp = '0;
                            1: smp = '1;
                            2: smp = lo_bound;
                            default: smp = hi_bound;
                        endcase
                    else
                        smp = $urandom;
                    issue_item(OP_MAP, smp, 4'($urandom), 16'($urandom), 24'($urandom), 0,
                               none);
                end
            end
        end

        start <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items, %0d of them stop loads.", items_sent, loads_sent);
        $display("Results: %0d mapped, %0d out of range, %0d without bracket.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
